// File: sv/complex_to_polar_converter_top_macros.svh
// Assertion macros for the rectangular to polar converter.
// Each expects clk and rst to be in scope where it is used.
`ifndef COMPLEX_TO_POLAR_CONVERTER_TOP_MACROS_SVH
`define COMPLEX_TO_POLAR_CONVERTER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cpc_pkg.sv
// Shared types, constants and the arctangent table of the polar converter.
// No dependencies; every module file imports this package.
package cpc_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int SQRT_STEPS        = 24;
  localparam int RUN_STEPS         = (CORDIC_ITERATIONS > SQRT_STEPS) ?
                                     CORDIC_ITERATIONS : SQRT_STEPS;
  localparam int CNT_W             = $clog2(RUN_STEPS);

  localparam int IN_W    = 24;
  localparam int MAG_W   = 24;
  localparam int TOL_W   = 12;
  localparam int PRESHIFT = 8;
  localparam int XY_W    = 35;
  localparam int Z_W     = 26;
  localparam int ATAN_W  = 22;
  localparam int FQ_W    = 23;
  localparam int ANG_W   = 25;
  localparam int SQ_W    = 2 * SQRT_STEPS;
  localparam int REM_W   = SQRT_STEPS + 3;

  localparam int DEG_UNIT = 65536;
  localparam logic [ANG_W-1:0] ANGLE_90  = ANG_W'(90 * DEG_UNIT);
  localparam logic [ANG_W-1:0] ANGLE_180 = ANG_W'(180 * DEG_UNIT);
  localparam logic [ANG_W-1:0] ANGLE_270 = ANG_W'(270 * DEG_UNIT);
  localparam logic [ANG_W-1:0] ANGLE_360 = ANG_W'(360 * DEG_UNIT);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4);

  typedef struct packed {
    logic signed [IN_W-1:0] real_part;
    logic signed [IN_W-1:0] imag_part;
  } cpc_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [ANG_W-1:0] angle_deg;
    logic             angle_undefined;
  } cpc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SUM,
    ST_RUN,
    ST_FIX
  } cpc_state_t;

  typedef struct packed {
    logic             load;
    logic             sq_re;
    logic             sq_im;
    logic             sum;
    logic             run;
    logic [CNT_W-1:0] step;
  } cpc_ctl_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = ATAN_W'(2949120);
      5'd1:    v = ATAN_W'(1740967);
      5'd2:    v = ATAN_W'(919879);
      5'd3:    v = ATAN_W'(466945);
      5'd4:    v = ATAN_W'(234379);
      5'd5:    v = ATAN_W'(117304);
      5'd6:    v = ATAN_W'(58666);
      5'd7:    v = ATAN_W'(29335);
      5'd8:    v = ATAN_W'(14668);
      5'd9:    v = ATAN_W'(7334);
      5'd10:   v = ATAN_W'(3667);
      5'd11:   v = ATAN_W'(1833);
      5'd12:   v = ATAN_W'(917);
      5'd13:   v = ATAN_W'(458);
      5'd14:   v = ATAN_W'(229);
      5'd15:   v = ATAN_W'(115);
      5'd16:   v = ATAN_W'(57);
      5'd17:   v = ATAN_W'(29);
      5'd18:   v = ATAN_W'(14);
      5'd19:   v = ATAN_W'(7);
      5'd20:   v = ATAN_W'(4);
      5'd21:   v = ATAN_W'(2);
      5'd22:   v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/complex_to_polar_converter_top.sv
// Rectangular to polar converter, top level: sequencer, quadrant fix-up,
// configuration register and result register. Depends on cpc_pkg,
// cpc_cordic, cpc_sqmag and the assertion macro header.
//
// A word is taken only in the idle state, so no new word is accepted until
// the last one has left the fix-up. Each word passes through the shared
// 24x24 squaring multiplier (real part, then imaginary part), one add, the
// run state in which the iteration counter steps the CORDIC stage and the
// square-root unit, and the fix-up that places the angle in its quadrant.
// A new word is taken while a finished result still waits in the output
// register; the fix-up holds only if that register is still occupied. The
// zero tolerance is sampled when a word is accepted; cfg_ready is always high.
`include "complex_to_polar_converter_top_macros.svh"

module complex_to_polar_converter_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_ready,
  input  cpc_pkg::cpc_in_t          sample,
  output logic                      result_valid,
  input  logic                      result_ready,
  output cpc_pkg::cpc_out_t         result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cpc_pkg::TOL_W-1:0] cfg_data
);
  import cpc_pkg::*;

  cpc_state_t       state;
  cpc_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [TOL_W-1:0] tol;
  logic             result_valid_next;
  logic             load_out;
  cpc_ctl_t         ctl;

  logic [IN_W-1:0]  ar_in;
  logic [IN_W-1:0]  ai_in;
  logic             re_neg;
  logic             im_neg;
  logic             re_zero;
  logic             im_zero;
  logic             near;

  logic [FQ_W-1:0]  first_quad;
  logic [MAG_W-1:0] magnitude;
  logic [ANG_W:0]   ang;
  logic [ANG_W-1:0] ang_fix;
  logic             undef;

  assign ar_in = sample.real_part[IN_W-1] ? IN_W'(-sample.real_part)
                                          : IN_W'(sample.real_part);
  assign ai_in = sample.imag_part[IN_W-1] ? IN_W'(-sample.imag_part)
                                          : IN_W'(sample.imag_part);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
      tol          <= TOL_RESET;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      result_valid <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        tol <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      re_neg  <= sample.real_part[IN_W-1];
      im_neg  <= sample.imag_part[IN_W-1];
      re_zero <= (ar_in == '0);
      im_zero <= (ai_in == '0);
      near    <= (ar_in < IN_W'(tol));
    end
    if (load_out) begin
      result.magnitude       <= magnitude;
      result.angle_deg       <= ang_fix;
      result.angle_undefined <= undef;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    sample_ready = 1'b0;
    load_out     = 1'b0;
    ctl          = '0;
    ctl.step     = cnt;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_SQ_RE;
        end
      end
      ST_SQ_RE: begin
        ctl.sq_re  = 1'b1;
        state_next = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        ctl.sq_im  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        ctl.sum    = 1'b1;
        cnt_next   = '0;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        ctl.run = 1'b1;
        if (cnt == CNT_W'(RUN_STEPS - 1)) begin
          state_next = ST_FIX;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FIX: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (load_out) begin
      result_valid_next = 1'b1;
    end else if (result_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  // place the first-quadrant angle from the signs, special cases first
  always_comb begin
    undef = 1'b0;
    ang   = '0;
    priority if (near) begin
      priority if (im_zero) begin
        undef = 1'b1;
      end else if (im_neg) begin
        ang = (ANG_W+1)'(ANGLE_270);
      end else begin
        ang = (ANG_W+1)'(ANGLE_90);
      end
    end else if (re_zero && im_zero) begin
      undef = 1'b1;
    end else if (re_neg && !im_neg) begin
      ang = (ANG_W+1)'(ANGLE_180) - (ANG_W+1)'(first_quad);
    end else if (re_neg) begin
      ang = (ANG_W+1)'(ANGLE_180) + (ANG_W+1)'(first_quad);
    end else if (im_neg) begin
      ang = (ANG_W+1)'(ANGLE_360) - (ANG_W+1)'(first_quad);
    end else begin
      ang = (ANG_W+1)'(first_quad);
    end
    ang_fix = (ang >= (ANG_W+1)'(ANGLE_360)) ? '0 : ang[ANG_W-1:0];
  end

  cpc_cordic u_cordic (
    .clk        (clk),
    .ctl        (ctl),
    .ar         (ar_in),
    .ai         (ai_in),
    .first_quad (first_quad)
  );

  cpc_sqmag u_sqmag (
    .clk       (clk),
    .ctl       (ctl),
    .ar        (ar_in),
    .ai        (ai_in),
    .magnitude (magnitude)
  );

  `CPC_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "ready high straight after a word was taken")
  `CPC_ASSERT_NEXT(a_fix_holds, state == ST_FIX && result_valid && !result_ready, state == ST_FIX && result_valid, "fix-up left while the result register was occupied")
  `CPC_ASSERT_NOW(a_angle_range, result_valid, result.angle_deg < ANGLE_360, "angle at or above full turn")
  `CPC_ASSERT_NOW(a_undef_zero, result_valid && result.angle_undefined, result.angle_deg == '0, "undefined angle not zero")

endmodule

// File: sv/cpc_cordic.sv
// CORDIC vectoring datapath: one micro-rotation per run cycle.
// Depends on cpc_pkg; driven by the sequencer in the top level.
module cpc_cordic (
  input  logic                      clk,
  input  cpc_pkg::cpc_ctl_t         ctl,
  input  logic [cpc_pkg::IN_W-1:0]  ar,
  input  logic [cpc_pkg::IN_W-1:0]  ai,
  output logic [cpc_pkg::FQ_W-1:0]  first_quad
);
  import cpc_pkg::*;

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  t;
  logic                   active;

  assign xs = x >>> ctl.step;
  assign ys = y >>> ctl.step;
  assign t  = $signed(Z_W'(atan_entry(5'(ctl.step))));
  assign active = ctl.run &&
                  ((CNT_W+1)'(ctl.step) < (CNT_W+1)'(CORDIC_ITERATIONS));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= $signed(XY_W'({ar, PRESHIFT'(0)}));
      y <= $signed(XY_W'({ai, PRESHIFT'(0)}));
      z <= '0;
    end else if (active) begin
      if (!y[XY_W-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end
    end
  end

  // clamp to the first quadrant
  always_comb begin
    priority if (z[Z_W-1]) begin
      first_quad = '0;
    end else if (z > $signed(Z_W'(ANGLE_90))) begin
      first_quad = FQ_W'(ANGLE_90);
    end else begin
      first_quad = z[FQ_W-1:0];
    end
  end

endmodule

// File: sv/cpc_sqmag.sv
// Magnitude datapath: shared squaring multiplier, sum, and a restoring
// square root that retires one result bit per run cycle. Depends on cpc_pkg.
module cpc_sqmag (
  input  logic                      clk,
  input  cpc_pkg::cpc_ctl_t         ctl,
  input  logic [cpc_pkg::IN_W-1:0]  ar,
  input  logic [cpc_pkg::IN_W-1:0]  ai,
  output logic [cpc_pkg::MAG_W-1:0] magnitude
);
  import cpc_pkg::*;

  logic [IN_W-1:0]  a_re;
  logic [IN_W-1:0]  a_im;
  logic [IN_W-1:0]  mul_a;
  logic [SQ_W-1:0]  prod;
  logic [SQ_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [MAG_W-1:0] root;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             active;

  assign mul_a  = ctl.sq_re ? a_re : a_im;
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign active = ctl.run &&
                  ((CNT_W+1)'(ctl.step) < (CNT_W+1)'(SQRT_STEPS));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_re <= ar;
      a_im <= ai;
    end
    if (ctl.sq_re || ctl.sq_im) begin
      prod <= SQ_W'(mul_a) * SQ_W'(mul_a);
    end
    if (ctl.sq_im) begin
      rad <= prod;
    end else if (ctl.sum) begin
      rad  <= rad + prod;
      rem  <= '0;
      root <= '0;
    end else if (active) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign magnitude = root;

endmodule
